>>> rtl/bmer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the minimax edge relaxation engine.
// No dependencies.
package bmer_pkg;

  localparam int unsigned NumVertices = 1024;
  localparam int unsigned Lanes       = 8;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned VtxWidth    = 10;
  localparam int unsigned FlagAddrW   = VtxWidth + 1;

  typedef enum logic [1:0] {
    FUNC_RELAX = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_ROUND = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  localparam logic CFG_BATCH_LANES = 1'b0;
  localparam logic CFG_USE_MASK    = 1'b1;

  typedef logic [ValueWidth-1:0] val_t;
  typedef val_t [Lanes-1:0]      row_t;
  typedef logic [Lanes-1:0]      flags_t;

  typedef struct packed {
    func_e                      func;
    logic [VtxWidth-1:0]        src_vertex;
    logic [VtxWidth-1:0]        dst_vertex;
    logic signed [31:0]         edge_weight;
    logic [2:0]                 lane;
    logic signed [31:0]         write_value;
    logic                       write_active;
  } in_t;

  typedef struct packed {
    logic [7:0]         updated_mask;
    logic               any_updated;
    logic               newly_activated;
    logic signed [31:0] read_value;
    logic               read_active;
  } out_t;

  typedef struct packed {
    row_t   row;
    flags_t nxt_flags;
    flags_t upd;
    logic   newly;
  } relax_res_t;

endpackage

>>> rtl/bmer_val_mem.sv
`timescale 1ns / 1ps
// Path value memory: one row of lane values per vertex, registered read.
// Depends on bmer_pkg.
module bmer_val_mem import bmer_pkg::*; (
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [VtxWidth-1:0] raddr_i,
  output row_t                rdata_o,
  input  logic                we_i,
  input  logic [VtxWidth-1:0] waddr_i,
  input  row_t                wdata_i
);

  row_t mem [NumVertices];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmer_flag_mem.sv
`timescale 1ns / 1ps
// Active flag memory: both banks, addressed by {bank, vertex}, registered read.
// Depends on bmer_pkg.
module bmer_flag_mem import bmer_pkg::*; (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [FlagAddrW-1:0] raddr_i,
  output flags_t               rdata_o,
  input  logic                 we_i,
  input  logic [FlagAddrW-1:0] waddr_i,
  input  flags_t               wdata_i
);

  flags_t mem [2*NumVertices];
  flags_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmer_relax_lanes.sv
`timescale 1ns / 1ps
// Per-lane relax datapath: candidate = max(src, weight), lower dst if larger.
// Depends on bmer_pkg.
module bmer_relax_lanes import bmer_pkg::*; (
  input  row_t               src_row_i,
  input  flags_t             src_flags_i,
  input  row_t               dst_row_i,
  input  flags_t             dst_nxt_i,
  input  logic signed [31:0] weight_i,
  input  logic [3:0]         batch_lanes_i,
  input  logic               use_mask_i,
  output relax_res_t         res_o
);

  always_comb begin
    logic signed [ValueWidth-1:0] sv;
    logic signed [ValueWidth-1:0] cand;
    logic                         go;
    res_o           = '0;
    res_o.row       = dst_row_i;
    res_o.nxt_flags = dst_nxt_i;
    for (int j = 0; j < Lanes; j++) begin
      sv   = $signed(src_row_i[j]);
      cand = (sv > weight_i) ? sv : weight_i;
      go   = (batch_lanes_i > 4'(j)) && (!use_mask_i || src_flags_i[j]);
      if (go && ($signed(dst_row_i[j]) > cand)) begin
        res_o.row[j] = cand;
        res_o.upd[j] = 1'b1;
        if (use_mask_i) begin
          if (!dst_nxt_i[j]) begin
            res_o.newly = 1'b1;
          end
          res_o.nxt_flags[j] = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/batched_minimax_edge_relax.sv
`timescale 1ns / 1ps
// Top level of the minimax edge relaxation engine: control sequencer,
// configuration registers, memories. Depends on bmer_pkg and the bmer_* modules.
//
// Usage:
//   Command channel: drive req_i and raise start_i; the command transfers at
//   the rising edge where start_i is high and busy_o is low.
//   Result channel: exactly one result per command, shown on rsp_o for one
//   cycle with done_o high. The receiver cannot stall; sample it then.
//   Order: a relax reads the source row, then the destination row, then
//   modifies and writes back; write, read and end round skip the destination
//   read. busy_o drops in the cycle the result shows (after end round only
//   once the sweep ends), and no new command transfers while busy_o is high.
//   Each memory has a single read port, so source and destination rows are
//   fetched one after another.
//   End round swaps the flag banks, then sweeps the new next bank clear, one
//   vertex a cycle, with busy_o high until the sweep ends.
//   Reset: both flag banks are swept clear, one entry a cycle, with busy_o
//   high. Path values are not cleared; write before read.
//   Configuration writes (cfg_we_i) land at once; issue them only when idle.
module batched_minimax_edge_relax import bmer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  in_t        req_i,
  output logic       done_o,
  output out_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_RDDST = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;

  logic [2:0]           state_q, state_d;
  in_t                  req_q;
  logic                 bank_q, bank_d;
  logic [FlagAddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic                 clr_all_q, clr_all_d;
  logic                 clr_bank_q, clr_bank_d;
  logic [3:0]           batch_lanes_q;
  logic                 use_mask_q;
  row_t                 src_row_q;
  flags_t               src_flags_q;
  logic                 done_q, done_d;
  out_t                 rsp_q, rsp_d;

  // memory ports
  logic                 val_re, val_we;
  logic [VtxWidth-1:0]  val_raddr, val_waddr;
  row_t                 val_rdata, val_wdata;
  logic                 flag_re, flag_we;
  logic [FlagAddrW-1:0] flag_raddr, flag_waddr;
  flags_t               flag_rdata, flag_wdata;
  relax_res_t           relax_res;

  bmer_val_mem u_val_mem (
    .clk_i   (clk_i),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata)
  );

  bmer_flag_mem u_flag_mem (
    .clk_i   (clk_i),
    .re_i    (flag_re),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata)
  );

  // In EXEC of a relax the memories hold the destination row and its next-bank flags.
  bmer_relax_lanes u_lanes (
    .src_row_i     (src_row_q),
    .src_flags_i   (src_flags_q),
    .dst_row_i     (val_rdata),
    .dst_nxt_i     (flag_rdata),
    .weight_i      (req_q.edge_weight),
    .batch_lanes_i (batch_lanes_q),
    .use_mask_i    (use_mask_q),
    .res_o         (relax_res)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_lanes_q <= 4'd8;
      use_mask_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BATCH_LANES: batch_lanes_q <= cfg_wdata_i;
        CFG_USE_MASK:    use_mask_q    <= cfg_wdata_i[0];
        default:         ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    row_t   wrow;
    flags_t wflags;
    state_d    = state_q;
    bank_d     = bank_q;
    clr_cnt_d  = clr_cnt_q;
    clr_all_d  = clr_all_q;
    clr_bank_d = clr_bank_q;
    done_d     = 1'b0;
    rsp_d      = '0;
    val_re     = 1'b0;
    val_raddr  = req_q.src_vertex;
    val_we     = 1'b0;
    val_waddr  = req_q.dst_vertex;
    val_wdata  = relax_res.row;
    flag_re    = 1'b0;
    flag_raddr = {bank_q, req_q.src_vertex};
    flag_we    = 1'b0;
    flag_waddr = {~bank_q, req_q.dst_vertex};
    flag_wdata = relax_res.nxt_flags;
    wrow       = val_rdata;
    wflags     = flag_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // fetch the source row and its current-bank flags
        val_re  = 1'b1;
        flag_re = 1'b1;
        state_d = (req_q.func == FUNC_RELAX) ? ST_RDDST : ST_EXEC;
      end
      ST_RDDST: begin
        // fetch the destination row and its next-bank flags
        val_re     = 1'b1;
        val_raddr  = req_q.dst_vertex;
        flag_re    = 1'b1;
        flag_raddr = {~bank_q, req_q.dst_vertex};
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        case (req_q.func)
          FUNC_RELAX: begin
            val_we                = |relax_res.upd;
            flag_we               = use_mask_q && (|relax_res.upd);
            rsp_d.updated_mask    = 8'(relax_res.upd);
            rsp_d.any_updated     = |relax_res.upd;
            rsp_d.newly_activated = relax_res.newly;
          end
          FUNC_WRITE: begin
            wrow[req_q.lane]   = ValueWidth'(req_q.write_value);
            wflags[req_q.lane] = req_q.write_active;
            val_we             = 1'b1;
            val_waddr          = req_q.src_vertex;
            val_wdata          = wrow;
            flag_we            = 1'b1;
            flag_waddr         = {bank_q, req_q.src_vertex};
            flag_wdata         = wflags;
          end
          FUNC_ROUND: begin
            // swap banks, then sweep the old current bank clear
            bank_d     = ~bank_q;
            clr_all_d  = 1'b0;
            clr_bank_d = bank_q;
            clr_cnt_d  = '0;
            state_d    = ST_CLR;
          end
          default: begin
            rsp_d.read_value  = 32'(val_rdata[req_q.lane]);
            rsp_d.read_active = flag_rdata[req_q.lane];
          end
        endcase
      end
      ST_CLR: begin
        flag_we    = 1'b1;
        flag_wdata = '0;
        flag_waddr = clr_all_q ? clr_cnt_q : {clr_bank_q, clr_cnt_q[VtxWidth-1:0]};
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (clr_all_q ? (&clr_cnt_q) : (&clr_cnt_q[VtxWidth-1:0])) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      bank_q     <= 1'b0;
      clr_cnt_q  <= '0;
      clr_all_q  <= 1'b1;
      clr_bank_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      bank_q     <= bank_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_all_q  <= clr_all_d;
      clr_bank_q <= clr_bank_d;
      done_q     <= done_d;
    end
  end

  // Payload registers: hold the command, the source row and the result.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q <= req_i;
    end
    if (state_q == ST_RDDST) begin
      src_row_q   <= val_rdata;
      src_flags_q <= flag_rdata;
    end
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Assertions.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_done_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without execute step");

  a_any_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.any_updated == (rsp_o.updated_mask != 8'd0)))
    else $error("any_updated disagrees with updated_mask");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> busy_o)
    else $error("idle during flag sweep");

endmodule
